// File: rtl/lzce_pkg.sv
// shared types and constants for the zero-crossing edge detector
`timescale 1ns / 1ps
package lzce_pkg;

   localparam int PIX_W   = 8;
   localparam int COEF_W  = 12;
   localparam int LOG_W   = 24;
   localparam int THR_W   = 24;
   localparam int FW_W    = 11;
   localparam int HGT_W   = 12;
   localparam int ROW_W   = 13;
   localparam int SUM_W   = 10;
   localparam int PROD_W  = 2 * LOG_W;
   localparam int STEP_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int COEF_FRAC_BITS = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CORNER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_EDGE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd5;

   localparam logic [FW_W-1:0]          RST_WIDTH   = 11'd374;
   localparam logic [HGT_W-1:0]         RST_HEIGHT  = 12'd374;
   localparam logic signed [COEF_W-1:0] RST_CORNER  = 12'sd103;
   localparam logic signed [COEF_W-1:0] RST_EDGE    = 12'sd205;
   localparam logic signed [COEF_W-1:0] RST_CENTER  = -12'sd1235;
   localparam logic [THR_W-1:0]         RST_THRESH  = 24'd1000;

   localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

   // last step of each iterated phase
   localparam logic [STEP_W-1:0] CONV_LAST = 3'd2;
   localparam logic [STEP_W-1:0] PAIR_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CONV,
      ST_PAIR,
      ST_DONE,
      ST_OUT
   } state_type;

endpackage

// File: rtl/log_zero_crossing_edge.sv
// top level: 3x3 laplacian-of-gaussian with zero-crossing edge marking
// Usage: grey pixels enter in raster order on the req_ channel (req_op high
// marks a pad item, read as a zero pixel). Each result on the rsp_ channel
// belongs to the position 2W+2 items earlier, so 2W+2 pads follow each frame
// to flush it; rsp_frame_end marks the frame's last result. The user must
// write registers on the csr_ channel only while the block is idle; the
// block itself does not enforce this. csr_ready is always high.
// Timing: one item at a time through a sequencer around two line stores;
// a new item is taken only once the last one is through. Each item passes
// LOAD and the CONV steps; from the second column of the second row on it
// also passes the PAIR steps and DONE, and an item with a result then
// passes OUT. The pace is set by the single shared convolution multiplier
// (three passes) and the single pair multiplier (four passes plus compare).
// Reset returns registers to their defaults and the row and column counters
// to zero; the line stores need no clearing. When the receiver stalls, the
// finished result waits in the output register and the sequencer holds the
// following item just before its own result.
`timescale 1ns / 1ps
module log_zero_crossing_edge
   import lzce_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_edge_pixel,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int AW = CW + 1;

   // configuration
   logic [FW_W-1:0]          width_ff;
   logic [HGT_W-1:0]         height_ff;
   logic signed [COEF_W-1:0] corner_ff, edge_coef_ff, center_ff;
   logic [THR_W-1:0]         thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_WIDTH;
         height_ff    <= RST_HEIGHT;
         corner_ff    <= RST_CORNER;
         edge_coef_ff <= RST_EDGE;
         center_ff    <= RST_CENTER;
         thresh_ff    <= RST_THRESH;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff     <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: height_ff    <= csr_data[HGT_W-1:0];
            CSR_COEF_CORNER:  corner_ff    <= $signed(csr_data[COEF_W-1:0]);
            CSR_COEF_EDGE:    edge_coef_ff <= $signed(csr_data[COEF_W-1:0]);
            CSR_COEF_CENTER:  center_ff    <= $signed(csr_data[COEF_W-1:0]);
            CSR_THRESHOLD:    thresh_ff    <= csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   logic [ROW_W-1:0] w_ext;
   logic [WW-1:0]    eff_w;
   logic [HGT_W-1:0] eff_h;
   logic [ROW_W-1:0] h_last;

   always_comb begin
      w_ext = ROW_W'(width_ff);
      if (w_ext < ROW_W'(3)) begin
         w_ext = ROW_W'(3);
      end else if (w_ext > ROW_W'(MAX_WIDTH)) begin
         w_ext = ROW_W'(MAX_WIDTH);
      end
      eff_w  = w_ext[WW-1:0];
      eff_h  = (height_ff < HGT_W'(3)) ? HGT_W'(3) : height_ff;
      h_last = ROW_W'(eff_h) - ROW_W'(1);
   end

   // sequencer
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept, log_wr_en, out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   logic st2_en_ff, out_en_ff;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      accept    = 1'b0;
      log_wr_en = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               accept   = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_CONV;
         ST_CONV: begin
            if (step_ff == CONV_LAST) begin
               state_in = st2_en_ff ? ST_PAIR : ST_IDLE;
            end
         end
         ST_PAIR: begin
            if (step_ff == PAIR_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            log_wr_en = 1'b1;
            state_in  = out_en_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_valid || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      step_in = (state_in != state_ff) ? '0 : step_ff + STEP_W'(1);
   end

   // positions
   logic [ROW_W-1:0] in_row_ff;
   logic [CW-1:0]    in_col_ff;
   logic [HGT_W-1:0] out_row_ff;
   logic [CW-1:0]    out_col_ff;

   logic             in_col_last, out_col_last, fend;
   logic [ROW_W-1:0] lr;
   logic [CW-1:0]    lc;
   logic             conv_en, st2_en, pair_en, out_en;

   always_comb begin
      in_col_last  = (WW'(in_col_ff) + WW'(1)) >= eff_w;
      out_col_last = (WW'(out_col_ff) + WW'(1)) >= eff_w;
      fend = out_col_last && (out_row_ff >= eff_h - HGT_W'(1));
      // position one step behind feeds the second stage
      if (in_col_ff != '0) begin
         lr = in_row_ff - ROW_W'(1);
         lc = in_col_ff - CW'(1);
      end else begin
         lr = in_row_ff - ROW_W'(2);
         lc = CW'(eff_w - WW'(1));
      end
      conv_en = (in_col_ff >= CW'(2)) && (in_row_ff >= ROW_W'(2))
                && (in_row_ff <= h_last);
      st2_en  = (in_row_ff >= ROW_W'(2))
                || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      pair_en = (lc >= CW'(2)) && (lr >= ROW_W'(2)) && (lr <= h_last);
      out_en  = (lr >= ROW_W'(2)) || ((lr == ROW_W'(1)) && (lc != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else if (accept) begin
         if (in_col_last) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_ff + ROW_W'(1);
         end else begin
            in_col_ff <= in_col_ff + CW'(1);
         end
      end else if (out_load) begin
         if (fend) begin
            in_row_ff  <= '0;
            in_col_ff  <= '0;
            out_row_ff <= '0;
            out_col_ff <= '0;
         end else if (out_col_last) begin
            out_col_ff <= '0;
            out_row_ff <= out_row_ff + HGT_W'(1);
         end else begin
            out_col_ff <= out_col_ff + CW'(1);
         end
      end
   end

   // per-item flags and addresses
   logic             conv_en_ff, pair_en_ff;
   logic [AW-1:0]    log_addr_ff;
   logic [PIX_W-1:0] px_ff, px_in;

   assign px_in = req_op ? '0 : req_pixel_in;

   always_ff @(posedge clock) begin
      if (accept) begin
         conv_en_ff  <= conv_en;
         st2_en_ff   <= st2_en;
         pair_en_ff  <= pair_en;
         out_en_ff   <= out_en;
         log_addr_ff <= {lr[0], lc};
         px_ff       <= px_in;
      end
   end

   // line stores
   logic [PIX_W-1:0] pix_rd_a, pix_rd_b;
   logic [LOG_W-1:0] log_rd_a, log_rd_b;
   logic signed [LOG_W-1:0] lg;

   lzce_line_mem #(.DATA_W(PIX_W), .ADDR_W(AW)) u_pix_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a ({in_row_ff[0], in_col_ff}),
      .rd_addr_b ({~in_row_ff[0], in_col_ff}),
      .rd_data_a (pix_rd_a),
      .rd_data_b (pix_rd_b),
      .wr_en     (accept),
      .wr_addr   ({in_row_ff[0], in_col_ff}),
      .wr_data   (px_in)
   );

   lzce_line_mem #(.DATA_W(LOG_W), .ADDR_W(AW)) u_log_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a ({lr[0], lc}),
      .rd_addr_b ({~lr[0], lc}),
      .rd_data_a (log_rd_a),
      .rd_data_b (log_rd_b),
      .wr_en     (log_wr_en),
      .wr_addr   (log_addr_ff),
      .wr_data   (lg)
   );

   // pixel window and mask sums
   logic [PIX_W-1:0] pw_ff [6];
   logic [SUM_W-1:0] sum_corner_ff, sum_edge_ff;
   logic [PIX_W-1:0] sum_center_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            pw_ff[i] <= '0;
         end
      end else if (state_ff == ST_LOAD) begin
         pw_ff[1] <= pw_ff[0];
         pw_ff[0] <= pix_rd_a;
         pw_ff[3] <= pw_ff[2];
         pw_ff[2] <= pix_rd_b;
         pw_ff[5] <= pw_ff[4];
         pw_ff[4] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         sum_corner_ff <= SUM_W'(pw_ff[1]) + SUM_W'(pix_rd_a)
                          + SUM_W'(pw_ff[5]) + SUM_W'(px_ff);
         sum_edge_ff   <= SUM_W'(pw_ff[0]) + SUM_W'(pw_ff[3])
                          + SUM_W'(pix_rd_b) + SUM_W'(pw_ff[4]);
         sum_center_ff <= pw_ff[2];
      end
   end

   // convolution: one multiply-accumulate per step
   logic signed [COEF_W-1:0] coef_sel, sum_sel;
   logic signed [LOG_W-1:0]  conv_prod, acc_ff;

   always_comb begin
      unique case (step_ff)
         3'd0: begin
            coef_sel = corner_ff;
            sum_sel  = $signed(COEF_W'(sum_corner_ff));
         end
         3'd1: begin
            coef_sel = edge_coef_ff;
            sum_sel  = $signed(COEF_W'(sum_edge_ff));
         end
         default: begin
            coef_sel = center_ff;
            sum_sel  = $signed(COEF_W'(sum_center_ff));
         end
      endcase
      conv_prod = coef_sel * sum_sel;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         acc_ff <= '0;
      end else if (state_ff == ST_CONV) begin
         acc_ff <= acc_ff + conv_prod;
      end
   end

   // border positions carry zero
   assign lg = conv_en_ff ? acc_ff : '0;

   // log window and pair test
   logic signed [LOG_W-1:0] lw_ff [6];
   logic signed [LOG_W-1:0] pair_a, pair_b;
   logic [LOG_W-1:0]        mag_a, mag_b;
   logic [PROD_W-1:0]       pair_prod_ff, limit;
   logic                    opp, opp_ff, hit_ff;

   always_comb begin
      unique case (step_ff)
         3'd0: begin
            pair_a = lw_ff[1];
            pair_b = lg;
         end
         3'd1: begin
            pair_a = lw_ff[0];
            pair_b = lw_ff[4];
         end
         3'd2: begin
            pair_a = $signed(log_rd_a);
            pair_b = lw_ff[5];
         end
         default: begin
            pair_a = lw_ff[3];
            pair_b = $signed(log_rd_b);
         end
      endcase
      opp   = (pair_a != '0) && (pair_b != '0) && (pair_a[LOG_W-1] != pair_b[LOG_W-1]);
      mag_a = pair_a[LOG_W-1] ? $unsigned(-pair_a) : $unsigned(pair_a);
      mag_b = pair_b[LOG_W-1] ? $unsigned(-pair_b) : $unsigned(pair_b);
      limit = PROD_W'(thresh_ff) << (2 * COEF_FRAC_BITS);
   end

   // product registered, then compared at the following step
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         hit_ff <= 1'b0;
      end else if (state_ff == ST_PAIR) begin
         pair_prod_ff <= mag_a * mag_b;
         opp_ff       <= opp && (step_ff != PAIR_LAST);
         if (step_ff != '0 && opp_ff && (pair_prod_ff > limit)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            lw_ff[i] <= '0;
         end
      end else if (log_wr_en) begin
         lw_ff[1] <= lw_ff[0];
         lw_ff[0] <= $signed(log_rd_a);
         lw_ff[3] <= lw_ff[2];
         lw_ff[2] <= $signed(log_rd_b);
         lw_ff[5] <= lw_ff[4];
         lw_ff[4] <= lg;
      end
   end

   // output register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_edge_ff;
   logic             rsp_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_edge_ff <= (hit_ff && pair_en_ff) ? EDGE_ON : EDGE_OFF;
         rsp_fend_ff <= fend;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_pixel = rsp_edge_ff;
   assign rsp_frame_end  = rsp_fend_ff;

`ifndef SYNTH
   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LOAD))
      else $error("accepted item did not start a memory read");

   a_log_wr_stage : assert property (@(posedge clock) disable iff (reset)
      log_wr_en |-> (st2_en_ff && $past(state_ff) == ST_PAIR))
      else $error("log store written outside the second stage");

   a_fend_clears : assert property (@(posedge clock) disable iff (reset)
      (out_load && fend) |=> (in_row_ff == '0 && in_col_ff == '0 && out_row_ff == '0))
      else $error("frame end did not clear positions");

   a_pair_steps : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAIR) |-> (step_ff <= PAIR_LAST))
      else $error("pair step counter overran");
`endif

endmodule

// File: rtl/lzce_line_mem.sv
// two-bank line store: one write port, two registered read ports
`timescale 1ns / 1ps
module lzce_line_mem
   import lzce_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// File: dv/tb_top.sv
// testbench for the laplacian-of-gaussian zero-crossing edge detector
`timescale 1ns / 1ps
module tb_top;
   import lzce_pkg::*;

   localparam int MAX_W       = 1024;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE      = 40;

   typedef struct {
      bit               op;
      logic [PIX_W-1:0] pix;
      bit               typed;
      bit               has_rsp;
      logic [PIX_W-1:0] edge_v;
      bit               fend;
   } pixel_item_type;

   typedef struct {
      logic [PIX_W-1:0] edge_v;
      bit               fend;
   } edge_result_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic                  req_op = 0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic [PIX_W-1:0]      rsp_edge_pixel;
   logic                  rsp_frame_end;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   log_zero_crossing_edge DUT (.*);

   always #5 clock = ~clock;

   // mirror of the block's registers and state
   int cfg_w, cfg_h, coef_c, coef_e, coef_m;
   longint cfg_thr;
   int pix_rows [2*MAX_W];
   int log_rows [2*MAX_W];
   int pix_win [6];
   int log_win [6];
   int in_row, in_col, out_row, out_col;

   pixel_item_type  pixel_queue [$];
   edge_result_type edge_expect [$];
   pixel_item_type  cur_item;

   int send_idle_pct = 0, recv_stall_pct = 0;
   int errors = 0, cycles = 0, items_sent = 0, results_seen = 0, edges_seen = 0;
   int frames_seen = 0;

   function automatic int width_eff();
      return cfg_w < 3 ? 3 : (cfg_w > MAX_W ? MAX_W : cfg_w);
   endfunction

   function automatic int height_eff();
      return cfg_h < 3 ? 3 : (cfg_h > 4095 ? 4095 : cfg_h);
   endfunction

   function automatic int sext12(logic [CSR_DATA_W-1:0] v);
      logic signed [COEF_W-1:0] s;
      s = v[COEF_W-1:0];
      return int'(s);
   endfunction

   function automatic void mirror_reset();
      cfg_w = RST_WIDTH; cfg_h = RST_HEIGHT;
      coef_c = RST_CORNER; coef_e = RST_EDGE; coef_m = RST_CENTER;
      cfg_thr = RST_THRESH;
      foreach (pix_rows[i]) begin pix_rows[i] = 0; log_rows[i] = 0; end
      foreach (pix_win[i]) begin pix_win[i] = 0; log_win[i] = 0; end
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
   endfunction

   function automatic void mirror_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_w = v[FW_W-1:0];
         CSR_FRAME_HEIGHT: cfg_h = v[HGT_W-1:0];
         CSR_COEF_CORNER:  coef_c = sext12(v);
         CSR_COEF_EDGE:    coef_e = sext12(v);
         CSR_COEF_CENTER:  coef_m = sext12(v);
         CSR_THRESHOLD:    cfg_thr = v[THR_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic bit zero_crossing(int a, int b);
      longint ma, mb;
      if (a == 0 || b == 0 || ((a < 0) == (b < 0))) return 0;
      ma = a < 0 ? -longint'(a) : longint'(a);
      mb = b < 0 ? -longint'(b) : longint'(b);
      return ma * mb > (cfg_thr << (2 * COEF_FRAC_BITS));
   endfunction

   // advances the mirror by one item, returns whether a result comes out
   function automatic bit edge_step(bit op, logic [PIX_W-1:0] pin, output edge_result_type res);
      int w, h, ir, ic, lr, lc, pa, pb, px, lg;
      int pc [3];
      int lcol [3];
      bit found;
      w = width_eff(); h = height_eff();
      ir = in_row; ic = in_col; lg = 0; found = 0;
      px = op ? 0 : int'(pin);
      pa = (ir & 1) * MAX_W + ic;
      pb = ((ir + 1) & 1) * MAX_W + ic;
      pc[0] = pix_rows[pa]; pc[1] = pix_rows[pb]; pc[2] = px;
      if (ic >= 2 && ir >= 2 && ir <= h - 1)
         lg = coef_c * (pix_win[1] + pc[0] + pix_win[5] + pc[2])
            + coef_e * (pix_win[0] + pix_win[3] + pc[1] + pix_win[4])
            + coef_m * pix_win[2];
      for (int r = 0; r < 3; r++) begin
         pix_win[r*2+1] = pix_win[r*2];
         pix_win[r*2] = pc[r];
      end
      pix_rows[pa] = px;
      if (ic + 1 >= w) begin in_col = 0; in_row = ir + 1; end
      else in_col = ic + 1;

      if (!(ir >= 2 || (ir == 1 && ic >= 1))) return 0;
      if (ic >= 1) begin lc = ic - 1; lr = ir - 1; end
      else begin lc = w - 1; lr = ir - 2; end

      // second stage works on log values one row and column behind
      pa = (lr & 1) * MAX_W + lc;
      pb = ((lr + 1) & 1) * MAX_W + lc;
      lcol[0] = log_rows[pa]; lcol[1] = log_rows[pb]; lcol[2] = lg;
      if (lc >= 2 && lr >= 2 && lr <= h - 1)
         found = zero_crossing(log_win[1], lcol[2]) || zero_crossing(log_win[0], log_win[4])
              || zero_crossing(lcol[0], log_win[5]) || zero_crossing(log_win[3], lcol[1]);
      for (int r = 0; r < 3; r++) begin
         log_win[r*2+1] = log_win[r*2];
         log_win[r*2] = lcol[r];
      end
      log_rows[pa] = lg;

      if (!(lr >= 2 || (lr == 1 && lc >= 1))) return 0;
      res.edge_v = found ? EDGE_ON : EDGE_OFF;
      res.fend = (out_col + 1 >= w) && (out_row >= h - 1);
      if (res.fend) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0; out_row++;
      end else begin
         out_col++;
      end
      return 1;
   endfunction

   // item driver, with prediction at acceptance
   always @(posedge clock) begin
      edge_result_type res;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            items_sent++;
            if (edge_step(cur_item.op, cur_item.pix, res)) begin
               if (cur_item.typed) begin
                  res.edge_v = cur_item.edge_v;
                  res.fend = cur_item.fend;
               end
               edge_expect.push_back(res);
            end else if (cur_item.typed && cur_item.has_rsp) begin
               res.edge_v = cur_item.edge_v;
               res.fend = cur_item.fend;
               edge_expect.push_back(res);
            end
         end
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_item = pixel_queue.pop_front();
               req_valid <= 1;
               req_op <= cur_item.op;
               req_pixel_in <= cur_item.pix;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result checker and receiver stalls
   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_edge_pixel == EDGE_ON) edges_seen++;
         if (rsp_frame_end) frames_seen++;
         if (edge_expect.size() == 0) begin
            errors++;
            $display("%0t: unexpected result edge=%0d frame_end=%0b", $time,
                     rsp_edge_pixel, rsp_frame_end);
         end else begin
            want = edge_expect.pop_front();
            if (rsp_edge_pixel !== want.edge_v) begin
               errors++;
               $display("%0t: edge_pixel expected %0d actual %0d", $time, want.edge_v,
                        rsp_edge_pixel);
            end
            if (rsp_frame_end !== want.fend) begin
               errors++;
               $display("%0t: frame_end expected %0b actual %0b", $time, want.fend,
                        rsp_frame_end);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, edge_expect.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      mirror_csr(idx, v);
      csr_valid <= 0;
   endtask

   task automatic set_coefs(int c, int e, int m, longint thr);
      csr_write(CSR_COEF_CORNER, CSR_DATA_W'(c & 12'hFFF));
      csr_write(CSR_COEF_EDGE, CSR_DATA_W'(e & 12'hFFF));
      csr_write(CSR_COEF_CENTER, CSR_DATA_W'(m & 12'hFFF));
      csr_write(CSR_THRESHOLD, CSR_DATA_W'(thr));
   endtask

   task automatic drain();
      wait (pixel_queue.size() == 0 && !req_valid && edge_expect.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one full frame followed by its flush pads; some pixels replaced by pads
   task automatic queue_frame(int pad_pct);
      pixel_item_type it;
      int w, h;
      w = width_eff(); h = height_eff();
      it.typed = 0; it.has_rsp = 0; it.edge_v = EDGE_OFF; it.fend = 0;
      for (int i = 0; i < w * h + 2 * w + 2; i++) begin
         it.pix = PIX_W'($urandom);
         it.op = (i >= w * h) || ($urandom_range(99) < pad_pct);
         pixel_queue.push_back(it);
      end
   endtask

   int rnd_start;
   pixel_item_type dir_table [17];

   initial begin
      mirror_reset();
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: 3x3 frame, every result lies on the border or next to it
      csr_write(CSR_FRAME_WIDTH, 3);
      csr_write(CSR_FRAME_HEIGHT, 3);
      for (int i = 0; i < 17; i++) begin
         dir_table[i].op = (i == 4) || (i >= 9);
         dir_table[i].pix = (i % 2) ? 8'd0 : 8'd255;
         dir_table[i].typed = 1;
         dir_table[i].has_rsp = (i >= 8);
         dir_table[i].edge_v = EDGE_OFF;
         dir_table[i].fend = (i == 16);
      end
      foreach (dir_table[i]) pixel_queue.push_back(dir_table[i]);
      drain();

      // random phases across the idling mixes
      rnd_start = items_sent;
      for (int p = 0; p < 12; p++) begin
         int ph_start;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         csr_write(CSR_FRAME_WIDTH, (p == 3) ? 0 : $urandom_range(3, 7));
         csr_write(CSR_FRAME_HEIGHT, (p == 5) ? 1 : $urandom_range(3, 6));
         case (p)
            0: set_coefs(RST_CORNER, RST_EDGE, RST_CENTER, 0);
            2: set_coefs(-2048, 2047, -2048, 24'hFFFFFF);
            4: set_coefs(2047, -2048, 2047, 0);
            6: set_coefs(-2048, -2048, 2047, $urandom_range(0, 4000));
            default: set_coefs($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                               $urandom_range(0, 4095) - 2048, $urandom_range(0, 20000));
         endcase
         ph_start = items_sent;
         while (items_sent - ph_start < 20) begin
            queue_frame(8);
            wait (pixel_queue.size() == 0 && !req_valid);
         end
         drain();
      end

      $display("ran %0d items (%0d after the directed frame) over %0d frames", items_sent,
               items_sent - rnd_start, frames_seen);
      $display("checked %0d results, %0d of them edge pixels", results_seen, edges_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
